// File: rtl/dwir_pkg.sv
// shared types and constants for the deque with indexed read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dwir_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int REQ_W   = 2;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;

    localparam int S_FIELDS_W = REQ_W + DATA_W + POS_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + DATA_W + COUNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_READ_AT    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dwir_cmd_t;

endpackage

`default_nettype wire

// File: rtl/dwir_ctrl.sv
// controller state machine: accepts a request, runs it, holds the result
// depends on dwir_pkg
`timescale 1ns / 1ps
`default_nettype none

module dwir_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output dwir_pkg::dwir_cmd_t cmd
);
    import dwir_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RESP);
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.exec = (state_reg == ST_EXEC);

endmodule

`default_nettype wire

// File: rtl/dwir_dp.sv
// datapath: request registers, ring pointers, slot memory, result fields
// depends on dwir_pkg
`timescale 1ns / 1ps
`default_nettype none

module dwir_dp #(
    parameter int DEPTH     = dwir_pkg::DEPTH_DEF,
    parameter int WORD_BITS = dwir_pkg::WORD_BITS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  dwir_pkg::dwir_cmd_t            cmd,
    input  wire  [dwir_pkg::S_TDATA_W-1:0] s_tdata,
    output logic [dwir_pkg::M_TDATA_W-1:0] m_tdata
);
    import dwir_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [WORD_BITS-1:0] mem [DEPTH];

    req_t                 req_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [IDX_W-1:0]     head_reg;
    logic [IDX_W-1:0]     head_next;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic                 ok_reg;
    logic                 ok_next;
    logic                 has_data_reg;
    logic                 has_data_next;
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [WORD_BITS-1:0] in_word;
    logic [DATA_W-1:0]    out_word;
    logic [WORD_BITS-1:0] data_sel;

    logic                 full;
    logic                 empty;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     fill_ext;
    logic [IDX_W-1:0]     rd_off;
    logic [IDX_W-1:0]     off;
    logic [IDX_W:0]       sum;
    logic [IDX_W-1:0]     wrapped;
    logic [IDX_W-1:0]     head_dec;
    logic [IDX_W-1:0]     addr;
    logic                 we;

    generate
        if (WORD_BITS >= DATA_W) begin : g_in_ext
            assign in_word  = WORD_BITS'(s_tdata[REQ_W +: DATA_W]);
            assign out_word = data_sel[DATA_W-1:0];
        end else begin : g_in_trunc
            assign in_word  = s_tdata[REQ_W +: WORD_BITS];
            assign out_word = DATA_W'(data_sel);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= req_t'(s_tdata[REQ_W-1:0]);
            word_reg <= in_word;
            pos_reg  <= s_tdata[REQ_W + DATA_W +: POS_W];
        end
    end

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pos_ext  = CMP_W'(pos_reg);
    assign fill_ext = CMP_W'(fill_reg);
    assign rd_off   = (pos_ext == fill_ext) ? IDX_W'(fill_ext - 1'b1) : IDX_W'(pos_ext);
    assign off      = (req_reg == REQ_PUSH_BACK) ? fill_reg[IDX_W-1:0] :
                      (req_reg == REQ_POP_FRONT) ? IDX_W'(1) : rd_off;
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign sum      = {1'b0, head_reg} + {1'b0, off};
    assign wrapped  = (sum >= (IDX_W + 1)'(DEPTH)) ? IDX_W'(sum - (IDX_W + 1)'(DEPTH))
                                                   : sum[IDX_W-1:0];

    always_comb begin
        ok_next       = 1'b0;
        has_data_next = 1'b0;
        addr          = wrapped;
        we            = 1'b0;
        head_next     = head_reg;
        fill_next     = fill_reg;
        case (req_reg)
            REQ_PUSH_FRONT: begin
                ok_next = !full;
                addr    = head_dec;
                we      = ok_next;
                if (ok_next) begin
                    head_next = head_dec;
                    fill_next = fill_reg + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                ok_next = !full;
                we      = ok_next;
                if (ok_next) fill_next = fill_reg + 1'b1;
            end
            REQ_POP_FRONT: begin
                ok_next       = !empty;
                has_data_next = ok_next;
                addr          = head_reg;
                if (ok_next) begin
                    head_next = wrapped;
                    fill_next = fill_reg - 1'b1;
                end
            end
            REQ_READ_AT: begin
                ok_next       = !empty && (pos_ext <= fill_ext);
                has_data_next = ok_next;
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
        end else if (cmd.exec) begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            ok_reg       <= ok_next;
            has_data_reg <= has_data_next;
        end
    end

    // slot memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (we) mem[addr] <= word_reg;
            rd_data_reg <= mem[addr];
        end
    end

    assign data_sel = has_data_reg ? rd_data_reg : '0;
    assign m_tdata  = M_TDATA_W'({COUNT_W'(fill_reg), out_word, ok_reg});

endmodule

`default_nettype wire

// File: rtl/deque_with_indexed_read_core.sv
// top level of the deque with indexed read: controller plus datapath
// depends on dwir_pkg, dwir_ctrl, dwir_dp
`timescale 1ns / 1ps
`default_nettype none

// Bounded deque of DEPTH words in a ring buffer with one result per request:
// push front, push back, pop front, or read at a position (0 is the front;
// a position equal to the count returns the back element). Each request holds
// the block through accept, one memory access and result, a sequence set by the
// single-port slot memory with registered read: the result is presented in the
// state after the access state, a result stall holds the block until the result
// is accepted, and the next request is taken in the cycle after the transfer.
// No clearing pass after reset.

module deque_with_indexed_read_core #(
    parameter int DEPTH     = dwir_pkg::DEPTH_DEF,
    parameter int WORD_BITS = dwir_pkg::WORD_BITS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // req_type[1:0], data_in[33:2], position[38:34]
    input  wire  [dwir_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // ok[0], data_out[32:1], count[37:33]
    output logic [dwir_pkg::M_TDATA_W-1:0] m_tdata
);
    import dwir_pkg::*;

    dwir_cmd_t cmd;

    dwir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dwir_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

    a_no_accept_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !m_tvalid)
        else $error("transfer accepted while a result is pending");

    a_exec_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (cmd.exec && !s_tready))
        else $error("accepted request not executed");

    a_result_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_tvalid)
        else $error("result not presented after execution");

endmodule

`default_nettype wire
